### rtl/core/cppt_pkg.sv
`timescale 1ns / 1ps
package cppt_pkg;
  localparam int COORD_BITS = 32;
  localparam int TAG_BITS = 16;
  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;
  localparam int XW = PW + 1;
  localparam int LW = PW;
  localparam int OW = XW + 2;
  localparam int LLO = LW / 2;
  localparam int LHI = LW - LLO;
  localparam int XLO = XW / 2;
  localparam int XHI = XW - XLO;
  localparam int TW = LW + XW;
  localparam int SW = TW + 2;
endpackage

### rtl/core/cppt_term_mul.sv
`timescale 1ns / 1ps
module cppt_term_mul import cppt_pkg::*; (
  input  logic                 clk,
  input  logic                 adv,
  input  logic [LW-1:0]        lift,
  input  logic signed [XW-1:0] xprod,
  output logic signed [TW-1:0] term
);
  logic [LLO-1:0]              ll;
  logic [LHI-1:0]              lh;
  logic [XLO-1:0]              xl;
  logic signed [XHI-1:0]       xh;
  logic signed [LLO+XLO+1:0]   pll;
  logic signed [LLO+XHI:0]     plh;
  logic signed [LHI+XLO+1:0]   phl;
  logic signed [LHI+XHI:0]     phh;
  logic signed [TW-1:0]        term_next;

  assign ll = lift[LLO-1:0];
  assign lh = lift[LW-1:LLO];
  assign xl = xprod[XLO-1:0];
  assign xh = xprod[XW-1:XLO];

  always_ff @(posedge clk) begin
    if (adv) begin
      pll <= $signed({1'b0, ll}) * $signed({1'b0, xl});
      plh <= $signed({1'b0, ll}) * xh;
      phl <= $signed({1'b0, lh}) * $signed({1'b0, xl});
      phh <= $signed({1'b0, lh}) * xh;
      term <= term_next;
    end
  end

  always_comb begin
    term_next = (TW'(phh) <<< (LLO + XLO)) + (TW'(plh) <<< XLO)
              + (TW'(phl) <<< LLO) + TW'(pll);
  end
endmodule

### rtl/core/circumcircle_point_test_unit.sv
`timescale 1ns / 1ps
// Delaunay in-circle test: is the query point strictly inside the circle
// through the three triangle corners? All coordinates are signed Q16.16.
// Input channel: in_valid/in_ready with the corner, query and tag fields.
// Output channel: out_valid/out_ready with inside_circle, degenerate and
// result_tag. Collinear corners give degenerate=1 and inside_circle=0.
// The answer is exact: wide products are split into partial products.
// Registers in order: differences, products, cross products and lifts,
// partial products, terms, output. Throughput: one transaction per cycle
// unless the receiver stalls; the six-stage multiply pipeline moves as a whole.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_ready drops; nothing is lost or repeated.
// Reset clears all valid bits; the pipeline is empty afterwards.
module circumcircle_point_test_unit import cppt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COORD_BITS-1:0] corner_a_x,
  input  logic [COORD_BITS-1:0] corner_a_y,
  input  logic [COORD_BITS-1:0] corner_b_x,
  input  logic [COORD_BITS-1:0] corner_b_y,
  input  logic [COORD_BITS-1:0] corner_c_x,
  input  logic [COORD_BITS-1:0] corner_c_y,
  input  logic [COORD_BITS-1:0] query_x,
  input  logic [COORD_BITS-1:0] query_y,
  input  logic [TAG_BITS-1:0]   triangle_tag,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  inside_circle,
  output logic                  degenerate,
  output logic [TAG_BITS-1:0]   result_tag
);
  logic adv;
  logic [4:0] vld;
  logic [TAG_BITS-1:0] tag [5];
  logic signed [DW-1:0] adx, ady, bdx, bdy, cdx, cdy;
  logic signed [PW-1:0] m_bc0, m_bc1, m_ca0, m_ca1, m_ab0, m_ab1;
  logic [PW-1:0] sq_ax, sq_ay, sq_bx, sq_by, sq_cx, sq_cy;
  logic signed [XW-1:0] xbc, xca, xab;
  logic [LW-1:0] la, lb, lc;
  logic [1:0] deg;
  logic [1:0] ori_pos;
  logic signed [TW-1:0] ta, tb, tc;
  logic signed [SW-1:0] det_next;
  logic signed [OW-1:0] orient_next;

  assign adv = !out_valid || out_ready;
  assign in_ready = adv;

  always_comb begin
    orient_next = OW'(xbc) + OW'(xca) + OW'(xab);
    det_next = SW'(ta) + SW'(tb) + SW'(tc);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vld <= {vld[3:0], in_valid};
      out_valid <= vld[4];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      adx <= $signed({corner_a_x[COORD_BITS-1], corner_a_x})
           - $signed({query_x[COORD_BITS-1], query_x});
      ady <= $signed({corner_a_y[COORD_BITS-1], corner_a_y})
           - $signed({query_y[COORD_BITS-1], query_y});
      bdx <= $signed({corner_b_x[COORD_BITS-1], corner_b_x})
           - $signed({query_x[COORD_BITS-1], query_x});
      bdy <= $signed({corner_b_y[COORD_BITS-1], corner_b_y})
           - $signed({query_y[COORD_BITS-1], query_y});
      cdx <= $signed({corner_c_x[COORD_BITS-1], corner_c_x})
           - $signed({query_x[COORD_BITS-1], query_x});
      cdy <= $signed({corner_c_y[COORD_BITS-1], corner_c_y})
           - $signed({query_y[COORD_BITS-1], query_y});
      tag[0] <= triangle_tag;

      m_bc0 <= bdx * cdy;
      m_bc1 <= cdx * bdy;
      m_ca0 <= cdx * ady;
      m_ca1 <= adx * cdy;
      m_ab0 <= adx * bdy;
      m_ab1 <= bdx * ady;
      sq_ax <= adx * adx;
      sq_ay <= ady * ady;
      sq_bx <= bdx * bdx;
      sq_by <= bdy * bdy;
      sq_cx <= cdx * cdx;
      sq_cy <= cdy * cdy;
      tag[1] <= tag[0];

      xbc <= XW'(m_bc0) - XW'(m_bc1);
      xca <= XW'(m_ca0) - XW'(m_ca1);
      xab <= XW'(m_ab0) - XW'(m_ab1);
      la <= sq_ax + sq_ay;
      lb <= sq_bx + sq_by;
      lc <= sq_cx + sq_cy;
      tag[2] <= tag[1];

      deg[0] <= orient_next == '0;
      deg[1] <= deg[0];
      tag[3] <= tag[2];
      tag[4] <= tag[3];

      degenerate <= deg[1];
      inside_circle <= !deg[1] && det_next != '0
                     && (det_next[SW-1] == !ori_pos[1]);
      result_tag <= tag[4];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ori_pos <= {ori_pos[0], !orient_next[OW-1]};
    end
  end

  cppt_term_mul u_term_a (.clk(clk), .adv(adv), .lift(la), .xprod(xbc), .term(ta));
  cppt_term_mul u_term_b (.clk(clk), .adv(adv), .lift(lb), .xprod(xca), .term(tb));
  cppt_term_mul u_term_c (.clk(clk), .adv(adv), .lift(lc), .xprod(xab), .term(tc));
endmodule

### rtl/core/cppt_checker.sv
`timescale 1ns / 1ps
module cppt_checker import cppt_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic                inside_circle,
  input logic                degenerate,
  input logic [TAG_BITS-1:0] result_tag
);
  a_deg_not_inside: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> !inside_circle) else $error("degenerate and inside");
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready) else $error("input stalled with empty output");
  a_empty_after_reset: assert property (@(posedge clk)
    $past(rst) && !rst |-> !out_valid) else $error("output valid after reset");
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_tag)
    && $stable(inside_circle) && $stable(degenerate)) else $error("result dropped");
endmodule

bind circumcircle_point_test_unit cppt_checker u_cppt_checker (
  .clk(clk), .rst(rst), .in_ready(in_ready), .out_valid(out_valid),
  .out_ready(out_ready), .inside_circle(inside_circle),
  .degenerate(degenerate), .result_tag(result_tag)
);

### test/circumcircle_point_test_unit_tb.sv
`timescale 1ns / 1ps
module circumcircle_point_test_unit_tb import cppt_pkg::*; ();

  typedef logic signed [255:0] wide_t;

  typedef struct {
    logic [COORD_BITS-1:0] ax, ay, bx, by, cx, cy, px, py;
    logic [TAG_BITS-1:0]   tag;
  } tri_query_t;

  typedef struct {
    logic                in_circle;
    logic                degen;
    logic [TAG_BITS-1:0] tag;
  } verdict_t;

  typedef struct {
    tri_query_t q;
    logic       fixed;
    verdict_t   v;
  } stim_row_t;

  localparam logic [COORD_BITS-1:0] CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic [COORD_BITS-1:0] CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};
  localparam logic [COORD_BITS-1:0] ONE  = 32'h0001_0000;
  localparam logic [COORD_BITS-1:0] NONE = 32'hFFFF_0000;
  localparam int LIMIT = 400000;
  localparam int N_RANDOM = 1100;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [COORD_BITS-1:0] corner_a_x = '0, corner_a_y = '0, corner_b_x = '0;
  logic [COORD_BITS-1:0] corner_b_y = '0, corner_c_x = '0, corner_c_y = '0;
  logic [COORD_BITS-1:0] query_x = '0, query_y = '0;
  logic [TAG_BITS-1:0]   triangle_tag = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic inside_circle, degenerate;
  logic [TAG_BITS-1:0] result_tag;

  verdict_t pending_verdicts[$];
  int errors = 0;
  int cycles = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_inside = 0;
  int n_degen = 0;
  bit sending_done = 0;
  bit long_hold = 0;

  circumcircle_point_test_unit u_top (.*);

  always #6 clk = ~clk;

  function automatic wide_t sx(logic [COORD_BITS-1:0] v);
    return wide_t'($signed(v));
  endfunction

  function automatic verdict_t incircle_verdict(tri_query_t q);
    wide_t adx, ady, bdx, bdy, cdx, cdy, xbc, xca, xab, orient, det;
    verdict_t v;
    adx = sx(q.ax) - sx(q.px);
    ady = sx(q.ay) - sx(q.py);
    bdx = sx(q.bx) - sx(q.px);
    bdy = sx(q.by) - sx(q.py);
    cdx = sx(q.cx) - sx(q.px);
    cdy = sx(q.cy) - sx(q.py);
    xbc = bdx * cdy - cdx * bdy;
    xca = cdx * ady - adx * cdy;
    xab = adx * bdy - bdx * ady;
    orient = xbc + xca + xab;
    det = (adx * adx + ady * ady) * xbc + (bdx * bdx + bdy * bdy) * xca
        + (cdx * cdx + cdy * cdy) * xab;
    v.degen = (orient == 0);
    v.in_circle = (orient != 0) && (det != 0) && ((det < 0) == (orient < 0));
    v.tag = q.tag;
    return v;
  endfunction

  function automatic logic [COORD_BITS-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? CMAX - $urandom_range(0, 3)
                                     : CMIN + $urandom_range(0, 3);
      default: return COORD_BITS'($signed($urandom_range(0, 8191)) - 4096) << 14;
    endcase
  endfunction

  function automatic tri_query_t rand_query();
    tri_query_t q;
    int s;
    q.ax = rand_coord(); q.ay = rand_coord();
    q.bx = rand_coord(); q.by = rand_coord();
    q.cx = rand_coord(); q.cy = rand_coord();
    q.px = rand_coord(); q.py = rand_coord();
    q.tag = TAG_BITS'($urandom());
    case ($urandom_range(0, 9))
      0: begin
        q.cx = q.ax + (q.bx - q.ax) * 2;
        q.cy = q.ay + (q.by - q.ay) * 2;
      end
      1: begin q.px = q.bx; q.py = q.by; end
      2: begin
        // small triangle with point near it: both answers common
        s = $urandom_range(1, 64);
        q.ax = $urandom_range(0, 2*s) - s; q.ay = $urandom_range(0, 2*s) - s;
        q.bx = $urandom_range(0, 2*s) - s; q.by = $urandom_range(0, 2*s) - s;
        q.cx = $urandom_range(0, 2*s) - s; q.cy = $urandom_range(0, 2*s) - s;
        q.px = $urandom_range(0, 2*s) - s; q.py = $urandom_range(0, 2*s) - s;
      end
      default: ;
    endcase
    return q;
  endfunction

  function automatic stim_row_t row(logic [COORD_BITS-1:0] ax, ay, bx, by, cx, cy, px, py,
                                    logic [TAG_BITS-1:0] tag, logic fixed,
                                    logic ins = 0, logic dg = 0);
    stim_row_t r;
    r.q = '{ax, ay, bx, by, cx, cy, px, py, tag};
    r.fixed = fixed;
    r.v = '{ins, dg, tag};
    return r;
  endfunction

  stim_row_t directed_rows[$];

  initial begin
    directed_rows = '{
      row('0, '0, '0, '0, '0, '0, '0, '0, 16'h0000, 1, 0, 1),
      row(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMIN, CMIN, 16'hFFFF, 1, 0, 1),
      row(CMIN, CMIN, '0, '0, CMAX, CMAX, '0, '0, 16'h5A5A, 1, 0, 1),
      row('0, '0, ONE, '0, ONE + ONE, '0, ONE, ONE, 16'h0003, 1, 0, 1),
      row('0, '0, ONE, '0, '0, ONE, '0, '0, 16'h0004, 1, 0, 0),
      row('0, '0, ONE, '0, '0, ONE, ONE, ONE, 16'h0005, 1, 0, 0),
      row('0, '0, ONE, '0, '0, ONE, 32'h4000, 32'h4000, 16'h0006, 1, 1, 0),
      row('0, '0, '0, ONE, ONE, '0, 32'h4000, 32'h4000, 16'h0007, 1, 1, 0),
      row('0, '0, ONE, '0, '0, ONE, NONE, NONE, 16'h0008, 1, 0, 0),
      row(CMIN, CMIN, CMAX, CMIN, CMIN, CMAX, '0, '0, 16'h0009, 0),
      row(CMIN, CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, 16'h000A, 0),
      row(CMAX, CMAX, CMIN, CMAX, CMAX, CMIN, CMIN, CMIN, 16'h000B, 0),
      row(CMAX, '0, '0, CMAX, CMIN, '0, '0, CMIN, 16'h000C, 0),
      row(CMAX, '0, '0, CMAX, CMIN, '0, 32'h1, 32'h1, 16'h000D, 0),
      row(NONE, NONE, ONE, NONE, '0, ONE, '0, '0, 16'h8000, 0),
      row(32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA,
          32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h3333_3333, 32'hCCCC_CCCC, 16'hAAAA, 0),
      row(32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555,
          32'hF0F0_F0F0, 32'h0F0F_0F0F, 32'hCCCC_CCCC, 32'h3333_3333, 16'h5555, 0)
    };
  end

  task automatic offer(tri_query_t q, verdict_t v);
    corner_a_x <= q.ax; corner_a_y <= q.ay;
    corner_b_x <= q.bx; corner_b_y <= q.by;
    corner_c_x <= q.cx; corner_c_y <= q.cy;
    query_x <= q.px; query_y <= q.py;
    triangle_tag <= q.tag;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_verdicts = {pending_verdicts, v};
    n_sent++;
  endtask

  task automatic pause_sender();
    int gap;
    gap = $urandom_range(0, 3) == 0 ? $urandom_range(1, 12) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    int burst;
    tri_query_t q;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed_rows[i]) begin
      offer(directed_rows[i].q, directed_rows[i].fixed ? directed_rows[i].v
                                                      : incircle_verdict(directed_rows[i].q));
      if (i % 5 == 4) pause_sender();
    end
    burst = 0;
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == 300) long_hold = 1;
      q = rand_query();
      offer(q, incircle_verdict(q));
      if (burst == 0) begin
        burst = $urandom_range(1, 40);
        pause_sender();
      end else begin
        burst--;
      end
    end
    in_valid <= 1'b0;
    sending_done = 1;
  end

  initial begin
    int hold_count;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (long_hold) begin
        hold_count = 0;
        out_ready <= 1'b0;
        while (hold_count < 60) begin
          @(posedge clk);
          hold_count++;
        end
        long_hold = 0;
      end else if (cycles % 400 < 150) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 2) != 0);
      end
    end
  end

  always @(posedge clk) begin
    verdict_t v;
    cycles <= cycles + 1;
    if (!rst && out_valid && out_ready) begin
      if (pending_verdicts.size() == 0) begin
        $error("result with nothing pending, tag %h", result_tag);
        errors++;
      end else begin
        v = pending_verdicts.pop_front();
        n_checked++;
        if (v.in_circle) n_inside++;
        if (v.degen) n_degen++;
        if (inside_circle !== v.in_circle) begin
          $error("inside_circle: expected %0b, got %0b", v.in_circle, inside_circle);
          errors++;
        end
        if (degenerate !== v.degen) begin
          $error("degenerate: expected %0b, got %0b", v.degen, degenerate);
          errors++;
        end
        if (result_tag !== v.tag) begin
          $error("result_tag: expected %h, got %h", v.tag, result_tag);
          errors++;
        end
      end
    end
  end

  initial begin
    wait (cycles >= LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    wait (sending_done);
    wait (pending_verdicts.size() == 0);
    repeat (20) @(posedge clk);
    $display("Checked %0d of %0d tests: %0d inside, %0d degenerate.",
             n_checked, n_sent, n_inside, n_degen);
    if (errors == 0 && pending_verdicts.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
